>>> hw/rtl/cfp_pkg.sv
// Shared constants and widths for the command frame parser.
package cfp_pkg;

  // Field widths of the byte stream and of one result.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TargetW  = 3;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ResultW  = ByteW + TargetW + ValueW;
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  // Only the first bytes of a payload ever reach the value word; later ones are counted only.
  localparam int unsigned StoreDepth = ValueW / ByteW;
  localparam int unsigned StoreIdxW  = $clog2(StoreDepth);

  // Sync pair that opens every frame.
  localparam logic [ByteW-1:0] SyncFirst  = 8'hFF;
  localparam logic [ByteW-1:0] SyncSecond = 8'hAA;

  // Command codes.
  localparam logic [ByteW-1:0] CmdThrottle = 8'h01;
  localparam logic [ByteW-1:0] CmdP        = 8'h02;
  localparam logic [ByteW-1:0] CmdD        = 8'h03;
  localparam logic [ByteW-1:0] CmdI        = 8'h04;
  localparam logic [ByteW-1:0] CmdAngleX   = 8'h05;
  localparam logic [ByteW-1:0] CmdAngleY   = 8'h06;
  localparam logic [ByteW-1:0] CmdAngleZ   = 8'h07;

  // Target codes.
  localparam logic [TargetW-1:0] TgtThrottle = 3'd0;
  localparam logic [TargetW-1:0] TgtUnknown  = 3'd7;

  // Parser phase codes.
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PhHunt  = 3'd0;
  localparam logic [PhaseW-1:0] PhSync2 = 3'd1;
  localparam logic [PhaseW-1:0] PhCmd   = 3'd2;
  localparam logic [PhaseW-1:0] PhLen   = 3'd3;
  localparam logic [PhaseW-1:0] PhData  = 3'd4;

endpackage

>>> hw/rtl/command_frame_parser_unit.sv
// Top level of the command frame parser: sync hunt, header capture, payload store, result.
// The byte that completes a frame loads the output register; the result shows in the next cycle.
// One byte per cycle unless stalled; the phase register and its logic take one pass a byte.
// The input stalls only when the next byte may complete a frame while a result is still held.
// Reset clears the phase, header holds, payload count, payload store and output valid at once.
module command_frame_parser_unit
  import cfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] rx_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // [7:0] cmd_code, [10:8] target, [42:11] value
);

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [ByteW-1:0]   cmd_q, cmd_d;
  logic [ByteW-1:0]   len_q, len_d;
  logic [CountW-1:0]  count_q, count_d, count_inc;
  logic [ByteW-1:0]   store_q [StoreDepth];
  logic [ByteW-1:0]   store_d [StoreDepth];
  logic               out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic               accept;
  logic               may_emit;
  logic               emit;
  logic [TargetW-1:0] tgt;
  logic [ValueW-1:0]  val;
  logic [ValueW-1:0]  word;

  // A result can only arise in the payload phase when the count reaches the length.
  assign may_emit = (phase_q == PhData) &&
                    ((count_q == len_q) || ((count_q + CountW'(1)) == len_q));

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i || !may_emit;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Next-state logic of the parser for one accepted byte.
  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    count_d   = count_q;
    count_inc = count_q;
    store_d   = store_q;
    emit      = 1'b0;
    if (accept) begin
      case (phase_q)
        PhSync2: begin
          phase_d = (s_axis_tdata_i == SyncSecond) ? PhCmd : PhHunt;
        end
        PhCmd: begin
          cmd_d   = s_axis_tdata_i;
          phase_d = PhLen;
        end
        PhLen: begin
          len_d   = s_axis_tdata_i;
          phase_d = PhData;
        end
        PhData: begin
          if (count_q < len_q) begin
            if (count_q < CountW'(StoreDepth)) begin
              store_d[count_q[StoreIdxW-1:0]] = s_axis_tdata_i;
            end
            count_inc = count_q + CountW'(1);
          end
          count_d = count_inc;
          if (count_inc == len_q) begin
            emit    = 1'b1;
            count_d = '0;
            phase_d = PhHunt;
          end
        end
        default: begin
          // Hunting, and any phase code that cannot arise.
          phase_d = (s_axis_tdata_i == SyncFirst) ? PhSync2 : PhHunt;
        end
      endcase
    end
  end

  // Result fields, built from the store including the byte written this cycle.
  assign word = {store_d[3], store_d[2], store_d[1], store_d[0]};

  always_comb begin
    if (cmd_q == CmdThrottle) begin
      tgt = TgtThrottle;
      val = {{(ValueW - ByteW){1'b0}}, store_d[0]};
    end else if (cmd_q inside {[CmdP:CmdAngleZ]}) begin
      tgt = TargetW'(cmd_q - ByteW'(1));
      val = word;
    end else begin
      tgt = TgtUnknown;
      val = '0;
    end
  end

  // Output register: loads on a completed frame, empties on a transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
      out_data_d  = {{(OutDataW - ResultW){1'b0}}, val, tgt, cmd_q};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and payload store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      cmd_q       <= '0;
      len_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      store_q     <= store_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> hw/rtl/cfp_checker.sv
// Port-level checker for the command frame parser, with its bind statement.
module cfp_checker
  import cfp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [ByteW-1:0]    s_axis_tdata_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [ByteW-1:0]   cmd;
  logic [TargetW-1:0] tgt;
  logic [ValueW-1:0]  val;

  assign cmd = m_axis_tdata_o[ByteW-1:0];
  assign tgt = m_axis_tdata_o[ByteW+TargetW-1:ByteW];
  assign val = m_axis_tdata_o[ResultW-1:ByteW+TargetW];

  // A held result stays unchanged until it is transferred.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A new result follows only an input transfer in the cycle before.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result without a preceding byte transfer");

  // Throttle carries a single byte.
  a_throttle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && cmd == CmdThrottle |-> tgt == TgtThrottle && val[ValueW-1:ByteW] == '0)
    else $error("throttle result malformed");

  // Unknown commands give the unknown target and a zero value.
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (cmd == 8'h00 || cmd > CmdAngleZ) |-> tgt == TgtUnknown && val == '0)
    else $error("unknown command result malformed");

  // Parameter commands select the target one below the command code.
  a_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && cmd >= CmdP && cmd <= CmdAngleZ |-> tgt == TargetW'(cmd - ByteW'(1)))
    else $error("parameter target mismatch");

endmodule

bind command_frame_parser_unit cfp_checker u_cfp_checker (.*);

>>> verif/tb_command_frame_parser_unit.sv
// Self-checking testbench for the command frame parser: directed table, random frames, predictor.
module tb_command_frame_parser_unit;
  import cfp_pkg::*;

  // Run sizes and limits.
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ModelDepth  = 8;
  localparam int unsigned DirectedLen = 26;
  localparam int unsigned HoldStart   = 700;
  localparam int unsigned HoldLen     = 120;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned MaxReports  = 10;

  // Target codes that the package does not name.
  localparam logic [TargetW-1:0] TgtP      = 3'd1;
  localparam logic [TargetW-1:0] TgtAngleZ = 3'd6;

  // One result as it sits in the output word, command in the lowest bits.
  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [TargetW-1:0] target;
    logic [ByteW-1:0]   cmd;
  } frame_result_t;

  // One byte to send, with an optional hand-written result and a drain request.
  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             typed;
    frame_result_t    exp;
    logic             pause;
  } stim_item_t;

  // One row of the directed table.
  typedef struct packed {
    logic [ByteW-1:0]   rx;
    logic               typed;
    logic [ByteW-1:0]   cmd;
    logic [TargetW-1:0] tgt;
    logic [ValueW-1:0]  val;
  } directed_row_t;

  typedef enum logic [1:0] {StallNone, StallPattern, StallCoin} stall_mode_e;

  // Directed bytes: a bad second sync byte that is itself 0xFF, an unknown command with
  // zero length, an overflowing payload, then a short payload that reads stale bytes.
  directed_row_t directed_table [DirectedLen] = '{
    '{SyncFirst,   1'b0, 8'h00, TgtThrottle, 32'h0},
    '{SyncFirst,   1'b0, 8'h00, TgtThrottle, 32'h0},
    '{SyncSecond,  1'b0, 8'h00, TgtThrottle, 32'h0},
    '{SyncFirst,   1'b0, 8'h00, TgtThrottle, 32'h0},
    '{SyncSecond,  1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'hFF,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h00,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h00,       1'b1, 8'hFF, TgtUnknown,  32'h0},
    '{SyncFirst,   1'b0, 8'h00, TgtThrottle, 32'h0},
    '{SyncSecond,  1'b0, 8'h00, TgtThrottle, 32'h0},
    '{CmdAngleZ,   1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'd9,        1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h11,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h22,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h33,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h44,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h55,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h66,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h77,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h88,       1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h99,       1'b1, CmdAngleZ, TgtAngleZ, 32'h44332211},
    '{SyncFirst,   1'b0, 8'h00, TgtThrottle, 32'h0},
    '{SyncSecond,  1'b0, 8'h00, TgtThrottle, 32'h0},
    '{CmdP,        1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'd1,        1'b0, 8'h00, TgtThrottle, 32'h0},
    '{8'h00,       1'b1, CmdP, TgtP, 32'h44332200}
  };

  logic [ByteW-1:0] command_codes [7] = '{
    CmdThrottle, CmdP, CmdD, CmdI, CmdAngleX, CmdAngleY, CmdAngleZ
  };

  // Clock, reset and block ports.
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [ByteW-1:0]    s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Predictor state.
  logic [PhaseW-1:0] parse_phase   = PhHunt;
  logic [ByteW-1:0]  held_command  = '0;
  logic [ByteW-1:0]  held_length   = '0;
  logic [CountW-1:0] payload_count = '0;
  logic [ByteW-1:0]  payload_bytes [ModelDepth] = '{default: '0};

  // Stimulus, expectations and bookkeeping.
  stim_item_t    byte_stream [$];
  frame_result_t pending_frames [$];
  stim_item_t    cur_item    = '0;
  bit            offering    = 1'b0;
  bit            drained     = 1'b0;
  int unsigned   burst_left  = 0;
  int unsigned   gap_left    = 0;
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;

  // Receiver state.
  stall_mode_e   stall_mode   = StallNone;
  int unsigned   stall_left   = 0;
  int unsigned   rx_cycle     = 0;
  logic [7:0]    stall_bits   = '0;
  logic          ready_next   = 1'b0;

  command_frame_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Advance the parser by one byte and build the frame result when one completes.
  task automatic parse_byte(input logic [ByteW-1:0] rx, output bit done,
                            output frame_result_t res);
    logic [ValueW-1:0] word;
    done = 1'b0;
    res  = '0;
    case (parse_phase)
      PhSync2: parse_phase = (rx == SyncSecond) ? PhCmd : PhHunt;
      PhCmd: begin
        held_command = rx;
        parse_phase  = PhLen;
      end
      PhLen: begin
        held_length = rx;
        parse_phase = PhData;
      end
      PhData: begin
        if (payload_count < held_length) begin
          if (payload_count < ModelDepth) payload_bytes[payload_count] = rx;
          payload_count = payload_count + 1'b1;
        end
        if (payload_count == held_length) begin
          word    = {payload_bytes[3], payload_bytes[2], payload_bytes[1], payload_bytes[0]};
          res.cmd = held_command;
          if (held_command == CmdThrottle) begin
            res.target = TgtThrottle;
            res.value  = {24'd0, payload_bytes[0]};
          end else if (held_command >= CmdP && held_command <= CmdAngleZ) begin
            res.target = TargetW'(held_command - CmdThrottle);
            res.value  = word;
          end else begin
            res.target = TgtUnknown;
            res.value  = '0;
          end
          done          = 1'b1;
          payload_count = '0;
          parse_phase   = PhHunt;
        end
      end
      // Undefined phase codes behave as hunting.
      default: parse_phase = (rx == SyncFirst) ? PhSync2 : PhHunt;
    endcase
  endtask

  // Compare one received result with the oldest pending frame.
  task automatic check_frame(input frame_result_t got);
    frame_result_t want;
    if (pending_frames.size() == 0) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("unexpected frame result: cmd %h target %0d value %h",
                 got.cmd, got.target, got.value);
    end else begin
      want = pending_frames.pop_front();
      if (got.cmd !== want.cmd || got.target !== want.target || got.value !== want.value) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("frame mismatch: cmd %h/%h target %0d/%0d value %h/%h (expected/actual)",
                   want.cmd, got.cmd, want.target, got.target, want.value, got.value);
      end
    end
  endtask

  task automatic queue_byte(input logic [ByteW-1:0] rx, input logic pause);
    stim_item_t item;
    item       = '0;
    item.rx    = rx;
    item.pause = pause;
    byte_stream.push_back(item);
  endtask

  // Directed table first, then mostly well-formed frames with noise and broken sync pairs.
  task automatic build_stimulus();
    stim_item_t   item;
    int unsigned  frame_bytes;
    int unsigned  len;
    int unsigned  choice;
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] b;
    bit           pause_next;
    bit           mid_drain_done;
    frame_bytes    = 0;
    pause_next     = 1'b1;
    mid_drain_done = 1'b0;
    foreach (directed_table[i]) begin
      item            = '0;
      item.rx         = directed_table[i].rx;
      item.typed      = directed_table[i].typed;
      item.exp.cmd    = directed_table[i].cmd;
      item.exp.target = directed_table[i].tgt;
      item.exp.value  = directed_table[i].val;
      byte_stream.push_back(item);
    end
    while (frame_bytes < RandomItems) begin
      choice = $urandom_range(0, 9);
      if (choice < 8) begin
        cmd = ($urandom_range(0, 6) != 0) ? command_codes[$urandom_range(0, 6)]
                                          : ByteW'($urandom);
        len = ($urandom_range(0, 32) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
        queue_byte(SyncFirst, pause_next);
        pause_next = 1'b0;
        queue_byte(SyncSecond, 1'b0);
        queue_byte(cmd, 1'b0);
        queue_byte(ByteW'(len), 1'b0);
        repeat (len) queue_byte(ByteW'($urandom), 1'b0);
        // A zero-length frame still consumes one more byte.
        if (len == 0) queue_byte(ByteW'($urandom), 1'b0);
        frame_bytes += 4 + ((len == 0) ? 1 : len);
        if (!mid_drain_done && frame_bytes > RandomItems / 2) begin
          pause_next     = 1'b1;
          mid_drain_done = 1'b1;
        end
      end else if (choice == 8) begin
        repeat ($urandom_range(1, 4)) queue_byte(ByteW'($urandom), 1'b0);
      end else begin
        b = ByteW'($urandom);
        if (b == SyncSecond) b = SyncFirst;
        queue_byte(SyncFirst, 1'b0);
        queue_byte(b, 1'b0);
      end
    end
  endtask

  // Both transfers are observed here, input first, then the next byte is offered.
  always @(posedge clk_i) begin
    bit            done;
    frame_result_t res;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        parse_byte(cur_item.rx, done, res);
        if (cur_item.typed) pending_frames.push_back(cur_item.exp);
        else if (done) pending_frames.push_back(res);
        offering = 1'b0;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) check_frame(m_axis_tdata_o[ResultW-1:0]);

      // Bursts of bytes separated by random gaps; a drain request waits for all results.
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_stream.size() > 0 &&
                     !(byte_stream[0].pause && pending_frames.size() > 0)) begin
          cur_item = byte_stream.pop_front();
          offering = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      s_axis_tvalid_i <= offering;
      s_axis_tdata_i  <= cur_item.rx;
      drained         <= !offering && byte_stream.size() == 0 && pending_frames.size() == 0;
    end
  end

  // Receiver: changing stall modes, plus one long hold-off so that the input backs up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLen) begin
        ready_next = 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 2));
          stall_left = $urandom_range(20, 150);
          stall_bits = 8'($urandom);
        end
        stall_left--;
        case (stall_mode)
          StallNone:    ready_next = 1'b1;
          StallPattern: ready_next = stall_bits[rx_cycle % 8];
          default:      ready_next = 1'($urandom_range(0, 1));
        endcase
      end
      m_axis_tready_i <= ready_next;
    end
  end

  // Cycle limit.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset, run the stimulus to completion and report.
  initial begin
    build_stimulus();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (drained);
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (pending_frames.size() != 0) begin
      error_count += pending_frames.size();
      $display("%0d expected frame results never arrived", pending_frames.size());
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
